FILE: design/wsp_pkg.sv
// Shared types, codes and the base64 lookup for the WebSocket frame parser.
// No dependencies; used by every module of the block.
`default_nettype none
package wsp_pkg;

  localparam logic [7:0] FRAME_OPEN  = 8'h00;
  localparam logic [7:0] FRAME_CLOSE = 8'hff;
  localparam logic [7:0] PAD_CHAR    = 8'h3d;

  typedef enum logic [2:0] {
    KIND_DATA     = 3'd0,
    KIND_END      = 3'd1,
    KIND_CLOSE    = 3'd2,
    KIND_BADSTART = 3'd3,
    KIND_LONG     = 3'd4,
    KIND_BAD64    = 3'd5
  } kind_t;

  typedef enum logic {
    CFG_FRAME_MODE  = 1'b0,
    CFG_MAX_PAYLOAD = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0] data;
    kind_t      kind;
  } item_t;

  typedef struct packed {
    logic [1:0]      cnt;
    item_t [2:0]     items;
  } cmd_t;

  typedef struct packed {
    logic       bad;
    logic       pad;
    logic [5:0] val;
  } b64_t;

  function automatic b64_t b64_decode(input logic [7:0] c);
    b64_t r;
    r = '{bad: 1'b0, pad: 1'b0, val: 6'd0};
    if (c >= 8'h41 && c <= 8'h5a) begin
      r.val = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7a) begin
      r.val = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r.val = 6'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2b) begin
      r.val = 6'd62;
    end else if (c == 8'h2f) begin
      r.val = 6'd63;
    end else if (c == PAD_CHAR) begin
      r.pad = 1'b1;
    end else begin
      r.bad = 1'b1;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: design/websocket_ietf00_frame_parser_top.sv
// Top level of the WebSocket (0x00 ... 0xff framing) deframer.
// Depends on wsp_pkg, wsp_front, wsp_queue and wsp_back.
//
// Usage: received bytes enter on in_valid/in_ready/in_byte, one transaction
// per byte. Each byte yields zero to three result transactions on
// out_valid/out_ready with out_byte, out_kind and out_last; out_last marks
// the final result caused by one input byte.
// Configuration writes use cfg_valid/cfg_ready with cfg_index (0 frame
// mode, 1 payload limit) and cfg_data; cfg_ready is always high and writes
// should be issued only while no results are outstanding.
// Each accepted byte's command is registered in the command queue and then
// loaded into the output sequencer, which presents its first result.
// Throughput: one byte per cycle, limited by one result per cycle on the
// output channel; a byte giving three results occupies the output until all
// three are taken; the queue of QUEUE_DEPTH commands absorbs the difference.
// When the receiver stalls, the queue fills and in_ready drops.
// After a close or an error the block ignores every byte until reset, but
// still delivers results already queued. Reset clears all state and the
// configuration returns to text mode with a limit of 65536 bytes.
`default_nettype none
module websocket_ietf00_frame_parser_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_byte,
  output logic [2:0]       out_kind,
  output logic             out_last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [23:0] cfg_data
);

  logic          q_full, q_valid, q_pop, push;
  wsp_pkg::cmd_t push_cmd, q_cmd;

  assign in_ready  = !q_full;
  assign cfg_ready = 1'b1;

  wsp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (in_valid && in_ready),
    .in_byte  (in_byte),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .push     (push),
    .push_cmd (push_cmd)
  );

  wsp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .pop_valid(q_valid),
    .pop_cmd  (q_cmd)
  );

  wsp_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_byte (out_byte),
    .out_kind (out_kind),
    .out_last (out_last)
  );

endmodule
`default_nettype wire

FILE: design/wsp_front.sv
// Front end: accepts bytes, tracks framing and base64 state, and builds one
// result command per byte. Depends on wsp_pkg.
`default_nettype none
module wsp_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          accept,
  input  wire logic [7:0]    in_byte,
  input  wire logic          cfg_we,
  input  wire logic          cfg_index,
  input  wire logic [23:0]   cfg_data,
  output logic               push,
  output wsp_pkg::cmd_t      push_cmd
);

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_FRAME = 2'd1,
    PH_HALT  = 2'd2
  } phase_t;

  phase_t        phase_r, phase_nxt;
  logic          mode_r;
  logic [23:0]   max_r;
  logic [24:0]   len_r, len_nxt, len_inc;
  logic [17:0]   gb_r, gb_nxt;
  logic [1:0]    gc_r, gc_nxt;
  logic [1:0]    pc_r, pc_nxt;
  wsp_pkg::cmd_t cmd;
  wsp_pkg::b64_t dec;
  logic          fail;
  wsp_pkg::kind_t fail_kind;

  assign len_inc = len_r + 25'd1;
  assign dec     = wsp_pkg::b64_decode(in_byte);

  always_comb begin
    phase_nxt = phase_r;
    len_nxt   = len_r;
    gb_nxt    = gb_r;
    gc_nxt    = gc_r;
    pc_nxt    = pc_r;
    fail      = 1'b0;
    fail_kind = wsp_pkg::KIND_BAD64;
    cmd       = '0;
    case (phase_r)
      PH_IDLE: begin
        if (in_byte == wsp_pkg::FRAME_OPEN) begin
          phase_nxt = PH_FRAME;
          len_nxt   = '0;
          gb_nxt    = '0;
          gc_nxt    = '0;
          pc_nxt    = '0;
        end else begin
          fail      = 1'b1;
          fail_kind = (in_byte == wsp_pkg::FRAME_CLOSE) ? wsp_pkg::KIND_CLOSE
                                                        : wsp_pkg::KIND_BADSTART;
        end
      end
      PH_FRAME: begin
        if (in_byte == wsp_pkg::FRAME_CLOSE) begin
          if (mode_r && pc_r == 2'd0 && gc_r == 2'd1) begin
            fail = 1'b1;
          end else begin
            if (mode_r && (gc_r == 2'd2 || (gc_r == 2'd3 && pc_r == 2'd1))) begin
              cmd.items[0] = '{data: gb_r[11:4], kind: wsp_pkg::KIND_DATA};
              cmd.items[1] = '{data: 8'd0, kind: wsp_pkg::KIND_END};
              cmd.cnt      = 2'd2;
            end else if (mode_r && gc_r == 2'd3) begin
              cmd.items[0] = '{data: gb_r[17:10], kind: wsp_pkg::KIND_DATA};
              cmd.items[1] = '{data: gb_r[9:2], kind: wsp_pkg::KIND_DATA};
              cmd.items[2] = '{data: 8'd0, kind: wsp_pkg::KIND_END};
              cmd.cnt      = 2'd3;
            end else begin
              cmd.items[0] = '{data: 8'd0, kind: wsp_pkg::KIND_END};
              cmd.cnt      = 2'd1;
            end
            phase_nxt = PH_IDLE;
            len_nxt   = '0;
            gb_nxt    = '0;
            gc_nxt    = '0;
            pc_nxt    = '0;
          end
        end else begin
          len_nxt = len_inc;
          if (len_inc > {1'b0, max_r}) begin
            fail      = 1'b1;
            fail_kind = wsp_pkg::KIND_LONG;
          end else if (!mode_r) begin
            cmd.items[0] = '{data: in_byte, kind: wsp_pkg::KIND_DATA};
            cmd.cnt      = 2'd1;
          end else if (dec.bad) begin
            fail = 1'b1;
          end else if (dec.pad) begin
            if (pc_r == 2'd0 && gc_r == 2'd2) begin
              gc_nxt = 2'd3;
              pc_nxt = 2'd1;
            end else if (pc_r == 2'd0 && gc_r == 2'd3) begin
              cmd.items[0] = '{data: gb_r[17:10], kind: wsp_pkg::KIND_DATA};
              cmd.items[1] = '{data: gb_r[9:2], kind: wsp_pkg::KIND_DATA};
              cmd.cnt      = 2'd2;
              gb_nxt       = '0;
              gc_nxt       = 2'd0;
              pc_nxt       = 2'd1;
            end else if (pc_r == 2'd1 && gc_r == 2'd3) begin
              cmd.items[0] = '{data: gb_r[11:4], kind: wsp_pkg::KIND_DATA};
              cmd.cnt      = 2'd1;
              gb_nxt       = '0;
              gc_nxt       = 2'd0;
              pc_nxt       = 2'd2;
            end else begin
              fail = 1'b1;
            end
          end else if (pc_r != 2'd0) begin
            fail = 1'b1;
          end else if (gc_r == 2'd3) begin
            cmd.items[0] = '{data: gb_r[17:10], kind: wsp_pkg::KIND_DATA};
            cmd.items[1] = '{data: {gb_r[9:2]}, kind: wsp_pkg::KIND_DATA};
            cmd.items[2] = '{data: {gb_r[1:0], dec.val}, kind: wsp_pkg::KIND_DATA};
            cmd.cnt      = 2'd3;
            gb_nxt       = '0;
            gc_nxt       = 2'd0;
          end else begin
            gb_nxt = {gb_r[11:0], dec.val};
            gc_nxt = gc_r + 2'd1;
          end
        end
      end
      default: begin
      end
    endcase
    if (fail) begin
      phase_nxt    = PH_HALT;
      cmd          = '0;
      cmd.items[0] = '{data: 8'd0, kind: fail_kind};
      cmd.cnt      = 2'd1;
    end
  end

  assign push     = accept && (cmd.cnt != 2'd0);
  assign push_cmd = cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      mode_r  <= 1'b0;
      max_r   <= 24'd65536;
      len_r   <= '0;
      gb_r    <= '0;
      gc_r    <= '0;
      pc_r    <= '0;
    end else begin
      if (accept) begin
        phase_r <= phase_nxt;
        len_r   <= len_nxt;
        gb_r    <= gb_nxt;
        gc_r    <= gc_nxt;
        pc_r    <= pc_nxt;
      end
      if (cfg_we) begin
        case (cfg_index)
          wsp_pkg::CFG_FRAME_MODE:  mode_r <= cfg_data[0];
          wsp_pkg::CFG_MAX_PAYLOAD: max_r  <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

endmodule
`default_nettype wire

FILE: design/wsp_queue.sv
// Short command queue between the front end and the output sequencer.
// Depends on wsp_pkg for the command type.
`default_nettype none
module wsp_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire wsp_pkg::cmd_t push_cmd,
  output logic               full,
  input  wire logic          pop,
  output logic               pop_valid,
  output wsp_pkg::cmd_t      pop_cmd
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  wsp_pkg::cmd_t   slots_r [DEPTH];
  logic [PW-1:0]   wr_r, rd_r;
  logic [CW-1:0]   cnt_r;
  logic            do_pop;

  assign full      = (cnt_r == FULL_CNT);
  assign pop_valid = (cnt_r != '0);
  assign pop_cmd   = slots_r[rd_r];
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= (wr_r == LAST_PTR) ? '0 : wr_r + PW'(1);
      end
      if (do_pop) begin
        rd_r <= (rd_r == LAST_PTR) ? '0 : rd_r + PW'(1);
      end
      if (push && !do_pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (do_pop && !push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule
`default_nettype wire

FILE: design/wsp_back.sv
// Output sequencer: holds one command and presents its result items one per
// cycle on the output channel while out_ready is high. Depends on wsp_pkg.
`default_nettype none
module wsp_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_valid,
  input  wire wsp_pkg::cmd_t q_cmd,
  output logic               q_pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [7:0]         out_byte,
  output logic [2:0]         out_kind,
  output logic               out_last
);

  wsp_pkg::cmd_t cmd_r;
  logic [1:0]    idx_r;
  logic          busy_r;
  logic          take, done;
  wsp_pkg::item_t cur;

  assign cur       = cmd_r.items[idx_r];
  assign out_valid = busy_r;
  assign out_byte  = cur.data;
  assign out_kind  = cur.kind;
  assign out_last  = (idx_r == cmd_r.cnt - 2'd1);
  assign take      = busy_r && out_ready;
  assign done      = take && out_last;
  assign q_pop     = q_valid && (!busy_r || done);

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r <= q_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 2'd0;
    end else if (q_pop) begin
      busy_r <= 1'b1;
      idx_r  <= 2'd0;
    end else if (done) begin
      busy_r <= 1'b0;
      idx_r  <= 2'd0;
    end else if (take) begin
      idx_r <= idx_r + 2'd1;
    end
  end

endmodule
`default_nettype wire

FILE: design/wsp_checker.sv
// Port-level checker for the frame parser top level, attached by bind.
// Depends on wsp_pkg for the result kind codes.
`default_nettype none
module wsp_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte,
  input wire logic [2:0] out_kind,
  input wire logic       out_last
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
      $stable(out_kind) && $stable(out_last))
    else $error("stalled output transaction changed");

  a_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != wsp_pkg::KIND_DATA |-> out_byte == 8'd0)
    else $error("non-data result carries a nonzero byte");

  a_ctrl_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != wsp_pkg::KIND_DATA |-> out_last)
    else $error("frame end or error result not marked last");

endmodule

bind websocket_ietf00_frame_parser_top wsp_checker u_wsp_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_byte (out_byte),
  .out_kind (out_kind),
  .out_last (out_last)
);
`default_nettype wire

FILE: tb/websocket_ietf00_frame_parser_top_tb.sv
// Testbench for websocket_ietf00_frame_parser_top: drives framed byte streams in
// text and base64 modes, predicts every result and checks it field by field.
// Depends on wsp_pkg and the RTL of the frame parser.
`timescale 1ns / 100ps
module websocket_ietf00_frame_parser_top_tb;

  localparam int SETTLE_CYCLES = 10;
  localparam int STALL_LIMIT   = 400;

  typedef enum logic [1:0] {
    AWAIT_OPEN,
    IN_FRAME,
    HALTED
  } parse_phase_t;

  typedef struct {
    logic [7:0]     data;
    wsp_pkg::kind_t kind;
    logic           last;
  } deframed_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic [2:0]  out_kind;
  logic        out_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [23:0] cfg_data = 24'd0;

  logic [7:0]   tx_bytes[$];
  deframed_t    due_results[$];
  int           n_queued = 0;
  int           n_accepted = 0;
  int           n_results = 0;
  int           errors = 0;
  int           tx_gap = 0;
  int           rx_gap = 0;
  int           stall_cycles = 0;
  logic         calm = 1'b0;

  // Shadow of the parser state and its configuration.
  logic         frame_mode_sh;
  logic [23:0]  max_payload_sh;
  parse_phase_t phase_sh;
  logic [24:0]  flen_sh;
  logic [17:0]  group_sh;
  logic [1:0]   group_n_sh;
  logic [1:0]   pad_sh;

  websocket_ietf00_frame_parser_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .out_kind  (out_kind),
    .out_last  (out_last),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    errors++;
  endtask

  function automatic void classify(input logic [7:0] c, output logic [5:0] v,
                                   output logic pad, output logic bad);
    pad = 1'b0;
    bad = 1'b0;
    v = 6'd0;
    if (c >= 8'h41 && c <= 8'h5a) begin
      v = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7a) begin
      v = 6'(c - 8'h47);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      v = 6'(c + 8'h04);
    end else if (c == 8'h2b) begin
      v = 6'd62;
    end else if (c == 8'h2f) begin
      v = 6'd63;
    end else if (c == wsp_pkg::PAD_CHAR) begin
      pad = 1'b1;
    end else begin
      bad = 1'b1;
    end
  endfunction

  function automatic logic [7:0] b64_char(input int v);
    if (v < 26) return 8'(8'h41 + v);
    if (v < 52) return 8'(8'h61 + v - 26);
    if (v < 62) return 8'(8'h30 + v - 52);
    return (v == 62) ? 8'h2b : 8'h2f;
  endfunction

  function automatic logic [7:0] rand_char();
    return b64_char($urandom_range(0, 63));
  endfunction

  function automatic void clear_frame_sh();
    flen_sh = '0;
    group_sh = '0;
    group_n_sh = '0;
    pad_sh = '0;
  endfunction

  // Works out the results one received byte causes and advances the shadow state.
  function automatic void deframe_byte(input logic [7:0] b);
    deframed_t      batch[$];
    logic [5:0]     sext;
    logic           is_pad;
    logic           is_bad;
    logic           err;
    wsp_pkg::kind_t err_kind;
    logic [23:0]    word;
    err = 1'b0;
    err_kind = wsp_pkg::KIND_BAD64;
    case (phase_sh)
      AWAIT_OPEN: begin
        if (b == wsp_pkg::FRAME_OPEN) begin
          clear_frame_sh();
          phase_sh = IN_FRAME;
        end else begin
          err = 1'b1;
          err_kind = (b == wsp_pkg::FRAME_CLOSE) ? wsp_pkg::KIND_CLOSE
                                                 : wsp_pkg::KIND_BADSTART;
        end
      end
      IN_FRAME: begin
        if (b == wsp_pkg::FRAME_CLOSE) begin
          if (frame_mode_sh && pad_sh == 2'd0 && group_n_sh == 2'd1) begin
            err = 1'b1;
          end else begin
            if (frame_mode_sh) begin
              if (group_n_sh == 2'd2 || (group_n_sh == 2'd3 && pad_sh == 2'd1)) begin
                batch.push_back('{group_sh[11:4], wsp_pkg::KIND_DATA, 1'b0});
              end else if (group_n_sh == 2'd3) begin
                batch.push_back('{group_sh[17:10], wsp_pkg::KIND_DATA, 1'b0});
                batch.push_back('{group_sh[9:2], wsp_pkg::KIND_DATA, 1'b0});
              end
            end
            batch.push_back('{8'h00, wsp_pkg::KIND_END, 1'b0});
            phase_sh = AWAIT_OPEN;
            clear_frame_sh();
          end
        end else begin
          flen_sh = flen_sh + 25'd1;
          if (flen_sh > {1'b0, max_payload_sh}) begin
            err = 1'b1;
            err_kind = wsp_pkg::KIND_LONG;
          end else if (!frame_mode_sh) begin
            batch.push_back('{b, wsp_pkg::KIND_DATA, 1'b0});
          end else begin
            classify(b, sext, is_pad, is_bad);
            if (is_bad) begin
              err = 1'b1;
            end else if (is_pad) begin
              if (pad_sh == 2'd0 && group_n_sh == 2'd2) begin
                group_n_sh = 2'd3;
                pad_sh = 2'd1;
              end else if (pad_sh == 2'd0 && group_n_sh == 2'd3) begin
                batch.push_back('{group_sh[17:10], wsp_pkg::KIND_DATA, 1'b0});
                batch.push_back('{group_sh[9:2], wsp_pkg::KIND_DATA, 1'b0});
                group_sh = '0;
                group_n_sh = '0;
                pad_sh = 2'd1;
              end else if (pad_sh == 2'd1 && group_n_sh == 2'd3) begin
                batch.push_back('{group_sh[11:4], wsp_pkg::KIND_DATA, 1'b0});
                group_sh = '0;
                group_n_sh = '0;
                pad_sh = 2'd2;
              end else begin
                err = 1'b1;
              end
            end else if (pad_sh != 2'd0) begin
              err = 1'b1;
            end else if (group_n_sh == 2'd3) begin
              word = {group_sh, sext};
              batch.push_back('{word[23:16], wsp_pkg::KIND_DATA, 1'b0});
              batch.push_back('{word[15:8], wsp_pkg::KIND_DATA, 1'b0});
              batch.push_back('{word[7:0], wsp_pkg::KIND_DATA, 1'b0});
              group_sh = '0;
              group_n_sh = '0;
            end else begin
              group_sh = {group_sh[11:0], sext};
              group_n_sh = group_n_sh + 2'd1;
            end
          end
        end
      end
      default: ;
    endcase
    if (err) begin
      batch.delete();
      batch.push_back('{8'h00, err_kind, 1'b0});
      phase_sh = HALTED;
    end
    if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
    foreach (batch[i]) due_results.push_back(batch[i]);
  endfunction

  // Sender: one byte per transaction from the pending queue, with idle bursts.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_gap = 0;
    end else if (!in_valid || in_ready) begin
      if (tx_gap > 0) begin
        in_valid <= 1'b0;
        tx_gap--;
      end else if (!calm && $urandom_range(0, 15) == 0) begin
        in_valid <= 1'b0;
        tx_gap = $urandom_range(0, 16);
      end else if (tx_bytes.size() > 0) begin
        in_valid <= 1'b1;
        in_byte <= tx_bytes.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: tracks configuration, predicts on each input transaction and
  // checks each result transaction against the oldest prediction.
  always @(posedge clk) begin
    deframed_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_gap = 0;
      frame_mode_sh = 1'b0;
      max_payload_sh = 24'd65536;
      phase_sh = AWAIT_OPEN;
      clear_frame_sh();
      due_results.delete();
      n_accepted = 0;
      n_results = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == wsp_pkg::CFG_FRAME_MODE) frame_mode_sh = cfg_data[0];
        else max_payload_sh = cfg_data;
      end
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind %0d byte %02h",
                                    out_kind, out_byte));
        end else begin
          want = due_results.pop_front();
          if (out_byte !== want.data)
            report_mismatch($sformatf("result %0d: out_byte %02h, expected %02h",
                                      n_results, out_byte, want.data));
          if (out_kind !== want.kind)
            report_mismatch($sformatf("result %0d: out_kind %0d, expected %0d",
                                      n_results, out_kind, want.kind));
          if (out_last !== want.last)
            report_mismatch($sformatf("result %0d: out_last %0b, expected %0b",
                                      n_results, out_last, want.last));
        end
        n_results++;
      end
      if (in_valid && in_ready) begin
        deframe_byte(in_byte);
        n_accepted++;
      end
      if (rx_gap > 0) begin
        out_ready <= 1'b0;
        rx_gap--;
      end else if (!calm && $urandom_range(0, 15) == 0) begin
        out_ready <= 1'b0;
        rx_gap = $urandom_range(0, 16);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("websocket_ietf00_frame_parser_top_tb failed");
    $finish;
  end

  task automatic send(input logic [7:0] b);
    tx_bytes.push_back(b);
    n_queued++;
  endtask

  task automatic send_text(input string s);
    foreach (s[i]) send(s[i]);
  endtask

  task automatic settle();
    while (n_accepted != n_queued || due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input wsp_pkg::cfg_idx_t idx, input logic [23:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
  endtask

  task automatic add_frame(input logic binary, input int limit);
    int cap;
    int len;
    int groups;
    int tail;
    int tail_len;
    cap = (limit > 16) ? 16 : limit;
    len = ($urandom_range(0, 3) == 0) ? cap : $urandom_range(0, cap);
    send(wsp_pkg::FRAME_OPEN);
    if (!binary) begin
      repeat (len) send(8'($urandom_range(0, 254)));
    end else begin
      groups = $urandom_range(0, len / 4);
      repeat (groups * 4) send(rand_char());
      tail = $urandom_range(0, 5);
      tail_len = (tail == 0) ? 0 : (tail == 1) ? 2 : (tail <= 3) ? 3 : 4;
      if (tail_len > len - 4 * groups) tail = 0;
      case (tail)
        1: repeat (2) send(rand_char());
        2: repeat (3) send(rand_char());
        3: begin
          repeat (2) send(rand_char());
          send(wsp_pkg::PAD_CHAR);
        end
        4: begin
          repeat (2) send(rand_char());
          repeat (2) send(wsp_pkg::PAD_CHAR);
        end
        5: begin
          repeat (3) send(rand_char());
          send(wsp_pkg::PAD_CHAR);
        end
        default: ;
      endcase
    end
    send(wsp_pkg::FRAME_CLOSE);
  endtask

  initial begin
    int         start;
    int         gen_limit;
    logic       gen_mode;
    logic [7:0] c;
    logic [5:0] v6;
    logic       p;
    logic       bad_c;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Text frame under the reset configuration, with the extreme payload bytes.
    send(wsp_pkg::FRAME_OPEN);
    send(8'h00);
    send(8'h80);
    send(8'h7f);
    send(8'hfe);
    send(wsp_pkg::FRAME_CLOSE);
    settle();
    write_reg(wsp_pkg::CFG_FRAME_MODE, 24'd1);
    send(wsp_pkg::FRAME_OPEN);
    send_text("TWFu+/==");
    send(wsp_pkg::FRAME_CLOSE);
    // Mode switched to text while a base64 group is half collected.
    send(wsp_pkg::FRAME_OPEN);
    send_text("QU");
    settle();
    write_reg(wsp_pkg::CFG_FRAME_MODE, 24'd0);
    send_text("a");
    send(wsp_pkg::FRAME_CLOSE);

    for (int ph = 0; ph < 6; ph++) begin
      settle();
      gen_mode = ph[0];
      case (ph)
        0: gen_limit = 0;
        1: gen_limit = 24'hffffff;
        2: gen_limit = $urandom_range(1, 6);
        3: gen_limit = 65536;
        4: gen_limit = $urandom_range(0, 24'hffffff);
        default: gen_limit = $urandom_range(7, 16);
      endcase
      calm = (ph == 5);
      write_reg(wsp_pkg::CFG_FRAME_MODE, 24'(gen_mode));
      write_reg(wsp_pkg::CFG_MAX_PAYLOAD, 24'(gen_limit));
      start = n_queued;
      while (n_queued - start < 30) add_frame(gen_mode, gen_limit);
    end

    // One halting event per run, then bytes that must be ignored.
    case ($urandom_range(0, 3))
      0: send(wsp_pkg::FRAME_CLOSE);
      1: send(8'($urandom_range(1, 254)));
      2: begin
        settle();
        gen_limit = $urandom_range(0, 4);
        write_reg(wsp_pkg::CFG_MAX_PAYLOAD, 24'(gen_limit));
        send(wsp_pkg::FRAME_OPEN);
        repeat (gen_limit + 1) send(rand_char());
      end
      default: begin
        settle();
        write_reg(wsp_pkg::CFG_FRAME_MODE, 24'd1);
        write_reg(wsp_pkg::CFG_MAX_PAYLOAD, 24'd65536);
        send(wsp_pkg::FRAME_OPEN);
        case ($urandom_range(0, 5))
          0: begin
            do begin
              c = 8'($urandom_range(0, 254));
              classify(c, v6, p, bad_c);
            end while (!bad_c);
            send(c);
          end
          1: send(8'h00);
          2: begin
            repeat ($urandom_range(0, 1)) send(rand_char());
            send(wsp_pkg::PAD_CHAR);
          end
          3: begin
            repeat (2) send(rand_char());
            send(wsp_pkg::PAD_CHAR);
            send(rand_char());
          end
          4: begin
            repeat (2) send(rand_char());
            repeat (2) send(wsp_pkg::PAD_CHAR);
            send($urandom_range(0, 1) ? wsp_pkg::PAD_CHAR : rand_char());
          end
          default: begin
            send(rand_char());
            send(wsp_pkg::FRAME_CLOSE);
          end
        endcase
      end
    endcase
    send(wsp_pkg::FRAME_OPEN);
    send(wsp_pkg::FRAME_CLOSE);
    repeat (3) send(8'($urandom_range(0, 255)));
    settle();

    if (errors == 0)
      $display("websocket_ietf00_frame_parser_top_tb passed");
    else
      $display("websocket_ietf00_frame_parser_top_tb failed");
    $finish;
  end

endmodule

FILE: filelist.f
design/wsp_pkg.sv
design/wsp_front.sv
design/wsp_queue.sv
design/wsp_back.sv
design/websocket_ietf00_frame_parser_top.sv
design/wsp_checker.sv
tb/websocket_ietf00_frame_parser_top_tb.sv
